>>> src/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// Types, codes and limits shared by the rational arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

	localparam int WORD_BITS = 64;
	localparam int WIDE_BITS = 2 * WORD_BITS;
	localparam int DEN_BITS  = WORD_BITS - 1;
	localparam int CNT_BITS  = $clog2(WIDE_BITS);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DIV0  = 2'd2;

	localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

	typedef logic [WIDE_BITS-1:0] wide_t;

	typedef struct packed {
		logic [1:0]                  mode;
		logic signed [WORD_BITS-1:0] a_numerator;
		logic [DEN_BITS-1:0]         a_denominator;
		logic signed [WORD_BITS-1:0] b_numerator;
		logic [DEN_BITS-1:0]         b_denominator;
	} req_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] result_numerator;
		logic [DEN_BITS-1:0]         result_denominator;
		logic [1:0]                  status;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_GCD,
		OP_DIV,
		OP_MUL
	} eng_op_t;

	typedef enum logic [3:0] {
		SEL_AM,
		SEL_BM,
		SEL_AD,
		SEL_BD,
		SEL_G,
		SEL_QA,
		SEL_QB,
		SEL_N,
		SEL_D,
		SEL_TA,
		SEL_TB
	} sel_t;

	typedef enum logic [1:0] {
		RES_FIN,
		RES_ZERO,
		RES_ERR1,
		RES_ERR2
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      eng_start;
		eng_op_t   eng_op;
		sel_t      src_x;
		sel_t      src_y;
		sel_t      dst;
		logic      eng_wr;
		logic      sum_wr;
		logic      res_wr;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic       eng_done;
		logic [1:0] mode;
		logic       den_zero;
		logic       b_min;
		logic       bm_zero;
		logic       sum_bad;
		logic       n_zero;
		logic       fin_bad;
	} stat_t;

	function automatic logic mag_fits(input logic neg, input wide_t m);
		return (m[WIDE_BITS-1:WORD_BITS] == '0) &&
			(!m[WORD_BITS-1] || (neg && m[WORD_BITS-2:0] == '0));
	endfunction

endpackage

`default_nettype wire

>>> src/rau_stream_if.sv
// ---------------------------------------------------------------------------
// rau_stream_if
// Valid/ready channel carrying one payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface rau_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/rau_engine.sv
// ---------------------------------------------------------------------------
// rau_engine
// Shared iterative unit: binary gcd, restoring divide, shift-add multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module rau_engine
	import rau_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire eng_op_t op,
	input  wire wide_t   x,
	input  wire wide_t   y,
	output logic         done,
	output wide_t        res
);

	typedef enum logic [7:0] {
		E_IDLE  = 8'b0000_0001,
		E_MUL   = 8'b0000_0010,
		E_DIV   = 8'b0000_0100,
		E_GINIT = 8'b0000_1000,
		E_GTWO  = 8'b0001_0000,
		E_GAODD = 8'b0010_0000,
		E_GLOOP = 8'b0100_0000,
		E_GSHL  = 8'b1000_0000
	} est_t;

	est_t                est_q;
	wide_t               a_q, b_q, acc_q;
	logic [CNT_BITS-1:0] cnt_q, k_q;
	logic                done_q, is_mul_q;
	logic [WIDE_BITS:0]  rem_sh;
	logic [WIDE_BITS:0]  rem_sub;

	assign rem_sh  = {acc_q, a_q[WIDE_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, b_q};
	assign done    = done_q;
	assign res     = is_mul_q ? acc_q : a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q    <= E_IDLE;
			done_q   <= 1'b0;
			is_mul_q <= 1'b0;
			cnt_q    <= '0;
			k_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (est_q)
				E_IDLE: begin
					if (start) begin
						a_q      <= x;
						b_q      <= y;
						acc_q    <= '0;
						cnt_q    <= '0;
						k_q      <= '0;
						is_mul_q <= (op == OP_MUL);
						case (op)
							OP_MUL:  est_q <= E_MUL;
							OP_DIV:  est_q <= E_DIV;
							default: est_q <= E_GINIT;
						endcase
					end
				end
				E_MUL: begin
					if (b_q[0])
						acc_q <= acc_q + a_q;
					a_q   <= a_q << 1;
					b_q   <= b_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(WORD_BITS - 1)) begin
						est_q  <= E_IDLE;
						done_q <= 1'b1;
					end
				end
				E_DIV: begin
					if (!rem_sub[WIDE_BITS]) begin
						acc_q <= rem_sub[WIDE_BITS-1:0];
						a_q   <= {a_q[WIDE_BITS-2:0], 1'b1};
					end else begin
						acc_q <= rem_sh[WIDE_BITS-1:0];
						a_q   <= {a_q[WIDE_BITS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(WIDE_BITS - 1)) begin
						est_q  <= E_IDLE;
						done_q <= 1'b1;
					end
				end
				E_GINIT: begin
					if (a_q == '0) begin
						a_q   <= b_q;
						est_q <= E_GSHL;
					end else if (b_q == '0) begin
						est_q <= E_GSHL;
					end else begin
						est_q <= E_GTWO;
					end
				end
				E_GTWO: begin
					if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						est_q <= E_GAODD;
					end
				end
				E_GAODD: begin
					if (!a_q[0])
						a_q <= a_q >> 1;
					else
						est_q <= E_GLOOP;
				end
				E_GLOOP: begin
					if (b_q == '0) begin
						est_q <= E_GSHL;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= b_q;
						b_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
				E_GSHL: begin
					if (k_q == '0) begin
						est_q  <= E_IDLE;
						done_q <= 1'b1;
					end else begin
						a_q <= a_q << 1;
						k_q <= k_q - 1'b1;
					end
				end
				default: est_q <= E_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/rau_dp.sv
// ---------------------------------------------------------------------------
// rau_dp
// Datapath: operand and work registers, shared engine, sum/sign logic, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rau_dp
	import rau_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output stat_t     stat,
	output rsp_t      rsp
);

	logic [WORD_BITS-1:0] am_q, bm_q;
	logic [DEN_BITS-1:0]  ad_q, bd_q;
	logic                 an_q, bn_q, neg_q, bmin_q;
	logic [1:0]           mode_q;
	wide_t                g_q, qa_q, qb_q, n_q, d_q, ta_q, tb_q;
	rsp_t                 rsp_q;

	logic [WORD_BITS-1:0] a_mag, b_mag;
	logic                 b_neg_eff;
	wide_t                src_x, src_y, eng_res, sum_v;
	logic                 sum_neg_raw, sum_neg;

	assign a_mag     = req.a_numerator[WORD_BITS-1] ? -req.a_numerator : req.a_numerator;
	assign b_mag     = req.b_numerator[WORD_BITS-1] ? -req.b_numerator : req.b_numerator;
	assign b_neg_eff = (req.mode == MODE_SUB && b_mag != '0) ?
		!req.b_numerator[WORD_BITS-1] : req.b_numerator[WORD_BITS-1];

	function automatic wide_t pick(input sel_t s, input logic [WORD_BITS-1:0] am,
		input logic [WORD_BITS-1:0] bm, input logic [DEN_BITS-1:0] ad,
		input logic [DEN_BITS-1:0] bd, input wide_t g, input wide_t qa, input wide_t qb,
		input wide_t n, input wide_t d);
		unique case (s)
			SEL_AM:  return WIDE_BITS'(am);
			SEL_BM:  return WIDE_BITS'(bm);
			SEL_AD:  return WIDE_BITS'(ad);
			SEL_BD:  return WIDE_BITS'(bd);
			SEL_G:   return g;
			SEL_QA:  return qa;
			SEL_QB:  return qb;
			SEL_N:   return n;
			default: return d;
		endcase
	endfunction

	assign src_x = pick(cmd.src_x, am_q, bm_q, ad_q, bd_q, g_q, qa_q, qb_q, n_q, d_q);
	assign src_y = pick(cmd.src_y, am_q, bm_q, ad_q, bd_q, g_q, qa_q, qb_q, n_q, d_q);

	rau_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.eng_start),
		.op     (cmd.eng_op),
		.x      (src_x),
		.y      (src_y),
		.done   (stat.eng_done),
		.res    (eng_res)
	);

	always_comb begin
		if (an_q == bn_q) begin
			sum_v       = ta_q + tb_q;
			sum_neg_raw = an_q;
		end else if (ta_q >= tb_q) begin
			sum_v       = ta_q - tb_q;
			sum_neg_raw = an_q;
		end else begin
			sum_v       = tb_q - ta_q;
			sum_neg_raw = bn_q;
		end
		sum_neg = sum_neg_raw && (sum_v != '0);
	end

	assign stat.mode     = mode_q;
	assign stat.den_zero = (ad_q == '0) || (bd_q == '0);
	assign stat.b_min    = bmin_q;
	assign stat.bm_zero  = (bm_q == '0);
	assign stat.sum_bad  = !mag_fits(sum_neg, sum_v) || (d_q[WIDE_BITS-1:DEN_BITS] != '0);
	assign stat.n_zero   = (n_q == '0);
	assign stat.fin_bad  = !mag_fits(neg_q, n_q) || (d_q[WIDE_BITS-1:DEN_BITS] != '0);
	assign rsp           = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			am_q   <= a_mag;
			bm_q   <= b_mag;
			ad_q   <= req.a_denominator;
			bd_q   <= req.b_denominator;
			an_q   <= req.a_numerator[WORD_BITS-1];
			bn_q   <= b_neg_eff;
			bmin_q <= (req.b_numerator == WORD_MIN);
			neg_q  <= req.a_numerator[WORD_BITS-1] ^ req.b_numerator[WORD_BITS-1];
		end
		if (cmd.eng_wr) begin
			case (cmd.dst)
				SEL_G:   g_q  <= eng_res;
				SEL_QA:  qa_q <= eng_res;
				SEL_QB:  qb_q <= eng_res;
				SEL_N:   n_q  <= eng_res;
				SEL_D:   d_q  <= eng_res;
				SEL_TA:  ta_q <= eng_res;
				default: tb_q <= eng_res;
			endcase
		end
		if (cmd.sum_wr) begin
			n_q   <= sum_v;
			neg_q <= sum_neg;
		end
		if (cmd.res_wr) begin
			unique case (cmd.res_kind)
				RES_FIN: begin
					rsp_q.result_numerator   <= neg_q ? -n_q[WORD_BITS-1:0] : n_q[WORD_BITS-1:0];
					rsp_q.result_denominator <= d_q[DEN_BITS-1:0];
					rsp_q.status             <= ST_OK;
				end
				RES_ZERO: begin
					rsp_q.result_numerator   <= '0;
					rsp_q.result_denominator <= DEN_BITS'(1);
					rsp_q.status             <= ST_OK;
				end
				RES_ERR1: begin
					rsp_q.result_numerator   <= '0;
					rsp_q.result_denominator <= '0;
					rsp_q.status             <= ST_RANGE;
				end
				default: begin
					rsp_q.result_numerator   <= '0;
					rsp_q.result_denominator <= '0;
					rsp_q.status             <= ST_DIV0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/rau_ctrl.sv
// ---------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the shared engine through each operation, handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
	import rau_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_CHECK = 17'h00002,
		S_GCD1  = 17'h00004,
		S_DIVA  = 17'h00008,
		S_DIVB  = 17'h00010,
		S_MULL  = 17'h00020,
		S_MULA  = 17'h00040,
		S_MULB  = 17'h00080,
		S_SUM   = 17'h00100,
		S_MULN  = 17'h00200,
		S_MULD  = 17'h00400,
		S_ZCHK  = 17'h00800,
		S_RGCD  = 17'h01000,
		S_RDN   = 17'h02000,
		S_RDD   = 17'h04000,
		S_FIN   = 17'h08000,
		S_DONE  = 17'h10000
	} st_t;

	st_t       st_q, st_d;
	logic      run_q, run_d, ov_q, ov_d;
	res_kind_t kind_q, kind_d;
	logic      unit_step;

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		st_d         = st_q;
		kind_d       = kind_q;
		run_d        = run_q;
		ov_d         = ov_q && !out_ready;
		unit_step    = 1'b0;
		cmd          = '0;
		cmd.eng_op   = OP_GCD;
		cmd.src_x    = SEL_AM;
		cmd.src_y    = SEL_BM;
		cmd.dst      = SEL_G;
		cmd.res_kind = kind_q;
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.den_zero) begin
					kind_d = RES_ERR2;
					st_d   = S_DONE;
				end else if (stat.mode == MODE_SUB && stat.b_min) begin
					kind_d = RES_ERR1;
					st_d   = S_DONE;
				end else if (stat.mode == MODE_DIV && stat.bm_zero) begin
					kind_d = RES_ERR2;
					st_d   = S_DONE;
				end else if (stat.mode == MODE_ADD || stat.mode == MODE_SUB) begin
					st_d = S_GCD1;
				end else begin
					st_d = S_MULN;
				end
			end
			S_GCD1: begin
				unit_step = 1'b1;
				cmd.src_x = SEL_AD;
				cmd.src_y = SEL_BD;
				cmd.dst   = SEL_G;
			end
			S_DIVA: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_DIV;
				cmd.src_x  = SEL_AD;
				cmd.src_y  = SEL_G;
				cmd.dst    = SEL_QA;
			end
			S_DIVB: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_DIV;
				cmd.src_x  = SEL_BD;
				cmd.src_y  = SEL_G;
				cmd.dst    = SEL_QB;
			end
			S_MULL: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_MUL;
				cmd.src_x  = SEL_QA;
				cmd.src_y  = SEL_BD;
				cmd.dst    = SEL_D;
			end
			S_MULA: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_MUL;
				cmd.src_x  = SEL_AM;
				cmd.src_y  = SEL_QB;
				cmd.dst    = SEL_TA;
			end
			S_MULB: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_MUL;
				cmd.src_x  = SEL_BM;
				cmd.src_y  = SEL_QA;
				cmd.dst    = SEL_TB;
			end
			S_SUM: begin
				if (stat.sum_bad) begin
					kind_d = RES_ERR1;
					st_d   = S_DONE;
				end else begin
					cmd.sum_wr = 1'b1;
					st_d       = S_ZCHK;
				end
			end
			S_MULN: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_MUL;
				cmd.src_x  = SEL_AM;
				cmd.src_y  = (stat.mode == MODE_MUL) ? SEL_BM : SEL_BD;
				cmd.dst    = SEL_N;
			end
			S_MULD: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_MUL;
				cmd.src_x  = SEL_AD;
				cmd.src_y  = (stat.mode == MODE_MUL) ? SEL_BD : SEL_BM;
				cmd.dst    = SEL_D;
			end
			S_ZCHK: begin
				if (stat.n_zero) begin
					kind_d = RES_ZERO;
					st_d   = S_DONE;
				end else begin
					st_d = S_RGCD;
				end
			end
			S_RGCD: begin
				unit_step = 1'b1;
				cmd.src_x = SEL_N;
				cmd.src_y = SEL_D;
				cmd.dst   = SEL_G;
			end
			S_RDN: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_DIV;
				cmd.src_x  = SEL_N;
				cmd.src_y  = SEL_G;
				cmd.dst    = SEL_N;
			end
			S_RDD: begin
				unit_step  = 1'b1;
				cmd.eng_op = OP_DIV;
				cmd.src_x  = SEL_D;
				cmd.src_y  = SEL_G;
				cmd.dst    = SEL_D;
			end
			S_FIN: begin
				kind_d = stat.fin_bad ? RES_ERR1 : RES_FIN;
				st_d   = S_DONE;
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.res_wr = 1'b1;
					ov_d       = 1'b1;
					st_d       = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase

		if (unit_step) begin
			cmd.eng_start = !run_q;
			run_d         = 1'b1;
			if (run_q && stat.eng_done) begin
				cmd.eng_wr = 1'b1;
				run_d      = 1'b0;
				case (st_q)
					S_GCD1:  st_d = S_DIVA;
					S_DIVA:  st_d = S_DIVB;
					S_DIVB:  st_d = S_MULL;
					S_MULL:  st_d = S_MULA;
					S_MULA:  st_d = S_MULB;
					S_MULB:  st_d = S_SUM;
					S_MULN:  st_d = S_MULD;
					S_MULD:  st_d = S_ZCHK;
					S_RGCD:  st_d = S_RDN;
					S_RDN:   st_d = S_RDD;
					default: st_d = S_FIN;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			run_q  <= 1'b0;
			ov_q   <= 1'b0;
			kind_q <= RES_FIN;
		end else begin
			st_q   <= st_d;
			run_q  <= run_d;
			ov_q   <= ov_d;
			kind_q <= kind_d;
		end
	end

endmodule

`default_nettype wire

>>> src/rational_arithmetic_unit.sv
// Duration: data dependent; a zero denominator, a negated most negative numerator or
// a zero divisor ends the request at the operand check, a zero product ends it after
// the numerator and denominator multiplies, and otherwise the gcd runs take most of it.
// Throughput: one request at a time; all gcd, divide and multiply steps share one
// iterative engine, and each step waits for the engine to finish before the next starts.
// A new request is taken while the previous result waits in the output register.
// Reset (arst_n low) clears the sequencer and valid flags; data is not cleared.
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply or divide two rationals, giving a reduced result.
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
	import rau_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	rau_stream_if.sink   req,
	rau_stream_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;
	req_t  req_data;
	rsp_t  rsp_data;

	assign req_data    = req.payload;
	assign rsp.payload = rsp_data;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_data),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp_data)
	);

endmodule

`default_nettype wire
